/* rtl/core/mcab_pkg.sv */
// Package for the multi-class admission budget block: status, class and
// register codes, payload widths and the request/result structs.
// No dependencies.
package mcab_pkg;

   localparam int TableDepthDefault = 64;
   localparam int ByteBitsDefault   = 40;

   localparam int CfgIdxBits = 3;

   // result status codes
   localparam logic [2:0] ST_ADMITTED  = 3'd0;
   localparam logic [2:0] ST_SATURATED = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NO_IDS    = 3'd4;
   localparam logic [2:0] ST_RELEASED  = 3'd5;
   localparam logic [2:0] ST_UNKNOWN   = 3'd6;

   // resource classes
   localparam logic [2:0] CL_DEVICES  = 3'd0;
   localparam logic [2:0] CL_GENS     = 3'd1;
   localparam logic [2:0] CL_TEXTURES = 3'd2;
   localparam logic [2:0] CL_BYTES    = 3'd3;
   localparam logic [2:0] CL_ENCODERS = 3'd4;

   // register indexes
   localparam logic [CfgIdxBits-1:0] REG_MAX_DEVICES  = 3'd0;
   localparam logic [CfgIdxBits-1:0] REG_MAX_GENS     = 3'd1;
   localparam logic [CfgIdxBits-1:0] REG_MAX_TEXTURES = 3'd2;
   localparam logic [CfgIdxBits-1:0] REG_MAX_BYTES    = 3'd3;
   localparam logic [CfgIdxBits-1:0] REG_MAX_ENCODERS = 3'd4;

   localparam logic ACT_ACQUIRE = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // decoded request handed from front to back (bytes kept at full 64 bits)
   typedef struct packed {
      logic        action;
      logic [7:0]  want_devices;
      logic [7:0]  want_generations;
      logic [15:0] want_textures;
      logic [63:0] want_texture_bytes;
      logic [7:0]  want_encoders;
      logic [31:0] release_id;
      logic        empty;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  saturated_class;
      logic [31:0] granted_id;
      logic [39:0] class_in_use;
      logic [39:0] class_requested;
      logic [39:0] class_limit;
      logic [6:0]  active_count;
      logic [31:0] rejected_total;
      logic [39:0] bytes_in_use;
      logic [39:0] bytes_peak;
   } rsp_item_type;

endpackage

/* rtl/core/mcab_front.sv */
// Front part: accepts request beats, unpacks fields and flags requests that want nothing.
// Holds a two-entry queue toward the back part. Depends on mcab_pkg.
module mcab_front
   import mcab_pkg::*;
#(
   parameter int BYTE_BITS = ByteBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 action,
   input  logic [7:0]           want_devices,
   input  logic [7:0]           want_generations,
   input  logic [15:0]          want_textures,
   input  logic [BYTE_BITS-1:0] want_texture_bytes,
   input  logic [7:0]           want_encoders,
   input  logic [31:0]          release_id,
   output logic                 q_valid,
   input  logic                 q_ready,
   output req_item_type         q_item
);

   req_item_type slot_ff [2];
   req_item_type slot_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // classify the incoming beat
   always_comb begin
      slot_in = '0;
      slot_in.action             = action;
      slot_in.want_devices       = want_devices;
      slot_in.want_generations   = want_generations;
      slot_in.want_textures      = want_textures;
      slot_in.want_texture_bytes = 64'(want_texture_bytes);
      slot_in.want_encoders      = want_encoders;
      slot_in.release_id         = release_id;
      slot_in.empty = (want_devices == '0) && (want_generations == '0) &&
                      (want_textures == '0) && (want_texture_bytes == '0) &&
                      (want_encoders == '0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready)
      else $error("queue accepts while full");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_empty_valid: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !q_valid)
      else $error("queue shows item while empty");

endmodule

/* rtl/core/mcab_back.sv */
// Back part: checks budgets, scans the table (acquires: one entry per cycle),
// updates totals and holds the result register. Depends on mcab_pkg.
module mcab_back
   import mcab_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int BYTE_BITS   = ByteBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  req_item_type         q_item,
   input  logic [7:0]           max_devices,
   input  logic [7:0]           max_generations,
   input  logic [15:0]          max_textures,
   input  logic [BYTE_BITS-1:0] max_texture_bytes,
   input  logic [7:0]           max_encoders,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsp_item_type         out_item
);

   localparam int IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntBits = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   req_item_type item_ff;

   logic [7:0]           used_dev_ff, used_gen_ff, used_enc_ff;
   logic [15:0]          used_tex_ff;
   logic [BYTE_BITS-1:0] used_bytes_ff, peak_ff;
   logic [31:0]          last_id_ff, rej_ff;
   logic [CntBits-1:0]   active_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   // table memory: key, packed counts, bytes
   logic [31:0]          key_mem   [TABLE_DEPTH];
   logic [39:0]          cnt_mem   [TABLE_DEPTH];
   logic [BYTE_BITS-1:0] bytes_mem [TABLE_DEPTH];
   logic [31:0]          key_rd_ff;
   logic [39:0]          cnt_rd_ff;
   logic [BYTE_BITS-1:0] bytes_rd_ff;

   logic [IdxBits-1:0] idx_ff;
   logic               found_ff;
   rsp_item_type       rsp_ff;
   logic               rsp_valid_ff;
   rsp_item_type       chk_rsp;

   logic [BYTE_BITS-1:0] iwb;
   assign iwb = item_ff.want_texture_bytes[BYTE_BITS-1:0];

   assign q_ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_ff;

   // saturation check per class (registered stage in S_CHECK)
   logic ex_dev, ex_gen, ex_tex, ex_byt, ex_enc;
   assign ex_dev = !(item_ff.want_devices <= max_devices &&
                     used_dev_ff <= max_devices - item_ff.want_devices);
   assign ex_gen = !(item_ff.want_generations <= max_generations &&
                     used_gen_ff <= max_generations - item_ff.want_generations);
   assign ex_tex = !(item_ff.want_textures <= max_textures &&
                     used_tex_ff <= max_textures - item_ff.want_textures);
   assign ex_byt = !(iwb <= max_texture_bytes &&
                     used_bytes_ff <= max_texture_bytes - iwb);
   assign ex_enc = !(item_ff.want_encoders <= max_encoders &&
                     used_enc_ff <= max_encoders - item_ff.want_encoders);

   logic last_idx;
   assign last_idx = (idx_ff == IdxBits'(TABLE_DEPTH - 1));

   // release hit on the current entry (registered read data)
   logic rel_hit;
   assign rel_hit = valid_ff[idx_ff] && (key_rd_ff == item_ff.release_id);

   // result fields decided by the checks; refusal order is fixed
   always_comb begin
      chk_rsp = '0;
      if (item_ff.action == ACT_RELEASE) begin
         chk_rsp.status = ST_UNKNOWN;
      end else if (item_ff.empty) begin
         chk_rsp.status = ST_EMPTY;
      end else if (ex_dev || ex_gen || ex_tex || ex_byt || ex_enc) begin
         chk_rsp.status = ST_SATURATED;
         priority if (ex_dev) begin
            chk_rsp.saturated_class = CL_DEVICES;
            chk_rsp.class_in_use    = 40'(used_dev_ff);
            chk_rsp.class_requested = 40'(item_ff.want_devices);
            chk_rsp.class_limit     = 40'(max_devices);
         end else if (ex_gen) begin
            chk_rsp.saturated_class = CL_GENS;
            chk_rsp.class_in_use    = 40'(used_gen_ff);
            chk_rsp.class_requested = 40'(item_ff.want_generations);
            chk_rsp.class_limit     = 40'(max_generations);
         end else if (ex_tex) begin
            chk_rsp.saturated_class = CL_TEXTURES;
            chk_rsp.class_in_use    = 40'(used_tex_ff);
            chk_rsp.class_requested = 40'(item_ff.want_textures);
            chk_rsp.class_limit     = 40'(max_textures);
         end else if (ex_byt) begin
            chk_rsp.saturated_class = CL_BYTES;
            chk_rsp.class_in_use    = 40'(64'(used_bytes_ff));
            chk_rsp.class_requested = 40'(64'(iwb));
            chk_rsp.class_limit     = 40'(64'(max_texture_bytes));
         end else begin
            chk_rsp.saturated_class = CL_ENCODERS;
            chk_rsp.class_in_use    = 40'(used_enc_ff);
            chk_rsp.class_requested = 40'(item_ff.want_encoders);
            chk_rsp.class_limit     = 40'(max_encoders);
         end
      end else if (last_id_ff == '1) begin
         chk_rsp.status = ST_NO_IDS;
      end else begin
         chk_rsp.status = ST_FULL;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (q_valid && q_ready) state_in = S_CHECK;
         S_CHECK: begin
            if (item_ff.action == ACT_RELEASE) begin
               state_in = (item_ff.release_id == '0) ? S_OUT : S_READ;
            end else if (item_ff.empty || ex_dev || ex_gen || ex_tex || ex_byt ||
                         ex_enc || last_id_ff == '1) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN:  state_in = (!valid_ff[idx_ff] || last_idx) ? S_APPLY : S_SCAN;
         S_READ:  state_in = S_APPLY;
         S_APPLY: state_in = (item_ff.action == ACT_RELEASE && !rel_hit && !last_idx) ?
                             S_READ : S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid && q_ready) item_ff <= q_item;
      key_rd_ff   <= key_mem[idx_ff];
      cnt_rd_ff   <= cnt_mem[idx_ff];
      bytes_rd_ff <= bytes_mem[idx_ff];
      if (state_ff == S_APPLY && item_ff.action == ACT_ACQUIRE && found_ff) begin
         key_mem[idx_ff]   <= last_id_ff + 32'd1;
         cnt_mem[idx_ff]   <= {item_ff.want_encoders, item_ff.want_textures,
                               item_ff.want_generations, item_ff.want_devices};
         bytes_mem[idx_ff] <= iwb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_dev_ff   <= '0;
         used_gen_ff   <= '0;
         used_tex_ff   <= '0;
         used_enc_ff   <= '0;
         used_bytes_ff <= '0;
         peak_ff       <= '0;
         last_id_ff    <= '0;
         rej_ff        <= '0;
         active_ff     <= '0;
         valid_ff      <= '0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && out_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               idx_ff   <= '0;
               found_ff <= 1'b0;
            end
            S_CHECK: begin
               rsp_ff <= chk_rsp;
               if (chk_rsp.status == ST_SATURATED && rej_ff != '1) rej_ff <= rej_ff + 32'd1;
            end
            // acquire: look for lowest free entry
            S_SCAN: begin
               if (!valid_ff[idx_ff]) found_ff <= 1'b1;
               else if (!last_idx) idx_ff <= idx_ff + IdxBits'(1);
            end
            // release: one registered read per entry, compare next cycle
            S_READ: ;
            S_APPLY: begin
               if (item_ff.action == ACT_ACQUIRE) begin
                  if (found_ff) begin
                     last_id_ff  <= last_id_ff + 32'd1;
                     valid_ff[idx_ff] <= 1'b1;
                     active_ff   <= active_ff + CntBits'(1);
                     used_dev_ff <= used_dev_ff + item_ff.want_devices;
                     used_gen_ff <= used_gen_ff + item_ff.want_generations;
                     used_tex_ff <= used_tex_ff + item_ff.want_textures;
                     used_enc_ff <= used_enc_ff + item_ff.want_encoders;
                     used_bytes_ff <= used_bytes_ff + iwb;
                     if (used_bytes_ff + iwb > peak_ff) peak_ff <= used_bytes_ff + iwb;
                     rsp_ff.status     <= ST_ADMITTED;
                     rsp_ff.granted_id <= last_id_ff + 32'd1;
                  end
               end else if (rel_hit) begin
                  valid_ff[idx_ff] <= 1'b0;
                  active_ff   <= active_ff - CntBits'(1);
                  used_dev_ff <= used_dev_ff - cnt_rd_ff[7:0];
                  used_gen_ff <= used_gen_ff - cnt_rd_ff[15:8];
                  used_tex_ff <= used_tex_ff - cnt_rd_ff[31:16];
                  used_enc_ff <= used_enc_ff - cnt_rd_ff[39:32];
                  used_bytes_ff <= used_bytes_ff - bytes_rd_ff;
                  rsp_ff.status <= ST_RELEASED;
               end else if (!last_idx) begin
                  idx_ff <= idx_ff + IdxBits'(1);
               end
            end
            S_OUT: begin
               rsp_valid_ff          <= 1'b1;
               rsp_ff.active_count   <= 7'(active_ff);
               rsp_ff.rejected_total <= rej_ff;
               rsp_ff.bytes_in_use   <= 40'(64'(used_bytes_ff));
               rsp_ff.bytes_peak     <= 40'(64'(peak_ff));
            end
            default: ;
         endcase
      end
   end

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_valid_ff)
      else $error("result not posted");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= used_bytes_ff)
      else $error("peak below in-use bytes");
   a_active: assert property (@(posedge clock) disable iff (reset)
      active_ff == CntBits'($countones(valid_ff)))
      else $error("active count mismatch");

endmodule

/* rtl/core/multi_class_admission_budget.sv */
// Top level of the multi-class admission budget block: register file,
// front queue and back engine. Depends on mcab_pkg, mcab_front, mcab_back.
//
//   channel | dir | handshake           | content
//   req     | in  | req_tvalid/tready   | acquire or release request
//   rsp     | out | rsp_tvalid/tready   | one result per request
//   csr     | in  | csr_valid/ready     | limit register write
//
// An acquire that passes its checks scans for a free entry, one per cycle,
// then applies; a release reads each table entry into a register and
// compares it in the apply state; refusals go from the check to the result.
// Reset is synchronous and clears all totals and the table's valid bits.
// The two-entry front queue keeps taking requests while the back is busy
// or its result waits, until it holds two.
module multi_class_admission_budget
   import mcab_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int BYTE_BITS   = ByteBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] action, [8:1] want_devices, [16:9] want_generations,
   // [32:17] want_textures, [BYTE_BITS+32:33] want_texture_bytes,
   // then want_encoders (8), release_id (32), zero fill
   input  logic [((BYTE_BITS+73+7)/8)*8-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] status, [5:3] saturated_class, [37:6] granted_id,
   // [77:38] class_in_use, [117:78] class_requested, [157:118] class_limit,
   // [164:158] active_count, [196:165] rejected_total,
   // [236:197] bytes_in_use, [276:237] bytes_peak, [279:277] zero
   output logic [279:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [CfgIdxBits-1:0] csr_index,
   input  logic [BYTE_BITS-1:0]  csr_data
);

   localparam int B = BYTE_BITS;

   logic [7:0]   max_dev_ff, max_gen_ff, max_enc_ff;
   logic [15:0]  max_tex_ff;
   logic [B-1:0] max_byt_ff;

   assign csr_ready = 1'b1;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dev_ff <= '0;
         max_gen_ff <= '0;
         max_tex_ff <= '0;
         max_byt_ff <= '0;
         max_enc_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_DEVICES:  max_dev_ff <= csr_data[7:0];
            REG_MAX_GENS:     max_gen_ff <= csr_data[7:0];
            REG_MAX_TEXTURES: max_tex_ff <= csr_data[15:0];
            REG_MAX_BYTES:    max_byt_ff <= csr_data;
            REG_MAX_ENCODERS: max_enc_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   logic         q_valid, q_ready;
   req_item_type q_item;
   rsp_item_type rsp_item;

   mcab_front #(.BYTE_BITS(B)) u_front (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .action             (req_tdata[0]),
      .want_devices       (req_tdata[8:1]),
      .want_generations   (req_tdata[16:9]),
      .want_textures      (req_tdata[32:17]),
      .want_texture_bytes (req_tdata[B+32:33]),
      .want_encoders      (req_tdata[B+40:B+33]),
      .release_id         (req_tdata[B+72:B+41]),
      .q_valid            (q_valid),
      .q_ready            (q_ready),
      .q_item             (q_item)
   );

   mcab_back #(.TABLE_DEPTH(TABLE_DEPTH), .BYTE_BITS(B)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_item            (q_item),
      .max_devices       (max_dev_ff),
      .max_generations   (max_gen_ff),
      .max_textures      (max_tex_ff),
      .max_texture_bytes (max_byt_ff),
      .max_encoders      (max_enc_ff),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_item          (rsp_item)
   );

   assign rsp_tdata = {3'b000, rsp_item.bytes_peak, rsp_item.bytes_in_use,
                       rsp_item.rejected_total, rsp_item.active_count,
                       rsp_item.class_limit, rsp_item.class_requested,
                       rsp_item.class_in_use, rsp_item.granted_id,
                       rsp_item.saturated_class, rsp_item.status};

endmodule

/* verif/tb_multi_class_admission_budget.sv */
// Self-checking testbench for multi_class_admission_budget: limit writes,
// acquire/release beats with random stalls, results checked against a local model.
// Depends on mcab_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_multi_class_admission_budget;
   import mcab_pkg::*;

   localparam int Depth    = 64;
   localparam int ReqBits  = 120;
   localparam int CycleCap = 3000000;
   localparam logic [39:0] BytesMax = 40'hFF_FFFF_FFFF;

   typedef struct {
      logic        action;
      logic [7:0]  devices;
      logic [7:0]  gens;
      logic [15:0] textures;
      logic [39:0] tex_bytes;
      logic [7:0]  encoders;
      logic [31:0] release_id;
   } budget_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [ReqBits-1:0] req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [279:0]       rsp_tdata;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CfgIdxBits-1:0] csr_index = '0;
   logic [39:0]        csr_data = '0;

   multi_class_admission_budget dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // limits and budget state mirrored from the block
   logic [63:0] lim [5];
   logic [63:0] used [5];
   logic [63:0] peak_bytes, issued_id, reject_cnt;
   logic        slot_held [Depth];
   logic [31:0] slot_id [Depth];
   logic [63:0] slot_amt [Depth][5];
   int          held_cnt;

   budget_req_type pending_reqs [$];
   rsp_item_type   expected_rsps [$];
   budget_req_type cur_req;
   int            err_cnt = 0;
   int            cycle = 0;
   int            admits = 0, sats = 0, fulls = 0, frees = 0;

   // no idling inside this window
   function automatic bit stall_now();
      if (cycle >= 30000 && cycle < 60000) return 1'b0;
      return $urandom_range(99) < 13;
   endfunction

   function automatic rsp_item_type budget_predict(budget_req_type r);
      rsp_item_type o;
      logic [63:0]  want [5];
      int           hit, slot;
      o = '0;
      hit = -1;
      slot = -1;
      want[0] = 64'(r.devices); want[1] = 64'(r.gens); want[2] = 64'(r.textures);
      want[3] = 64'(r.tex_bytes); want[4] = 64'(r.encoders);
      if (r.action == ACT_ACQUIRE) begin
         if ((want[0] | want[1] | want[2] | want[3] | want[4]) == 0) begin
            o.status = ST_EMPTY;
         end else begin
            for (int k = 0; k < 5 && hit < 0; k++)
               if (!(want[k] <= lim[k] && used[k] <= lim[k] - want[k])) hit = k;
            if (hit >= 0) begin
               o.status = ST_SATURATED;
               o.saturated_class = 3'(hit);
               o.class_in_use = used[hit][39:0];
               o.class_requested = want[hit][39:0];
               o.class_limit = lim[hit][39:0];
               if (reject_cnt < 64'hFFFF_FFFF) reject_cnt++;
               sats++;
            end else if (issued_id >= 64'hFFFF_FFFF) begin
               o.status = ST_NO_IDS;
            end else begin
               for (int i = 0; i < Depth && slot < 0; i++)
                  if (!slot_held[i]) slot = i;
               if (slot < 0) begin
                  o.status = ST_FULL;
                  fulls++;
               end else begin
                  issued_id++;
                  o.status = ST_ADMITTED;
                  o.granted_id = issued_id[31:0];
                  slot_held[slot] = 1'b1;
                  slot_id[slot] = issued_id[31:0];
                  held_cnt++;
                  for (int k = 0; k < 5; k++) begin
                     slot_amt[slot][k] = want[k];
                     used[k] += want[k];
                  end
                  if (used[3] > peak_bytes) peak_bytes = used[3];
                  admits++;
               end
            end
         end
      end else begin
         if (r.release_id != 0)
            for (int i = 0; i < Depth && slot < 0; i++)
               if (slot_held[i] && slot_id[i] == r.release_id) slot = i;
         if (slot < 0) begin
            o.status = ST_UNKNOWN;
         end else begin
            for (int k = 0; k < 5; k++) used[k] -= slot_amt[slot][k];
            slot_held[slot] = 1'b0;
            held_cnt--;
            o.status = ST_RELEASED;
            frees++;
         end
      end
      o.active_count = 7'(held_cnt);
      o.rejected_total = reject_cnt[31:0];
      o.bytes_in_use = used[3][39:0];
      o.bytes_peak = peak_bytes[39:0];
      return o;
   endfunction

   // request driver: one beat held until accepted
   always @(posedge clock) begin
      logic nxt_valid;
      cycle <= cycle + 1;
      nxt_valid = req_tvalid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.insert(expected_rsps.size(), budget_predict(cur_req));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending_reqs.size() > 0 && !stall_now()) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= {7'd0, cur_req.release_id, cur_req.encoders, cur_req.tex_bytes,
                          cur_req.textures, cur_req.gens, cur_req.devices, cur_req.action};
            nxt_valid = 1'b1;
         end
      end
      req_tvalid <= nxt_valid;
   end

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         err_cnt++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            $error("result beat with nothing expected");
            err_cnt++;
         end else begin
            e = expected_rsps.pop_front();
            check_field("status", 64'(e.status), 64'(rsp_tdata[2:0]));
            check_field("saturated_class", 64'(e.saturated_class), 64'(rsp_tdata[5:3]));
            check_field("granted_id", 64'(e.granted_id), 64'(rsp_tdata[37:6]));
            check_field("class_in_use", 64'(e.class_in_use), 64'(rsp_tdata[77:38]));
            check_field("class_requested", 64'(e.class_requested),
                        64'(rsp_tdata[117:78]));
            check_field("class_limit", 64'(e.class_limit), 64'(rsp_tdata[157:118]));
            check_field("active_count", 64'(e.active_count), 64'(rsp_tdata[164:158]));
            check_field("rejected_total", 64'(e.rejected_total),
                        64'(rsp_tdata[196:165]));
            check_field("bytes_in_use", 64'(e.bytes_in_use), 64'(rsp_tdata[236:197]));
            check_field("bytes_peak", 64'(e.bytes_peak), 64'(rsp_tdata[276:237]));
            check_field("zero_fill", 64'(0), 64'(rsp_tdata[279:277]));
         end
      end
      rsp_tready <= reset ? 1'b0 : !stall_now();
   end

   always @(posedge clock) begin
      if (cycle > CycleCap) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_limit(logic [CfgIdxBits-1:0] idx, logic [39:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MAX_DEVICES:  lim[0] = 64'(val[7:0]);
         REG_MAX_GENS:     lim[1] = 64'(val[7:0]);
         REG_MAX_TEXTURES: lim[2] = 64'(val[15:0]);
         REG_MAX_BYTES:    lim[3] = 64'(val);
         REG_MAX_ENCODERS: lim[4] = 64'(val[7:0]);
         default: ;
      endcase
   endtask

   // wait until every beat is answered, then out-wait the slowest scan
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (2 * Depth + 20) @(posedge clock);
   endtask

   task automatic set_limits(logic [39:0] d, logic [39:0] g, logic [39:0] t,
                             logic [39:0] b, logic [39:0] e);
      drain();
      write_limit(REG_MAX_DEVICES, d);
      write_limit(REG_MAX_GENS, g);
      write_limit(REG_MAX_TEXTURES, t);
      write_limit(REG_MAX_BYTES, b);
      write_limit(REG_MAX_ENCODERS, e);
   endtask

   task automatic push_acq(logic [7:0] d, logic [7:0] g, logic [15:0] t,
                           logic [39:0] b, logic [7:0] e);
      budget_req_type r;
      r = '{ACT_ACQUIRE, d, g, t, b, e, $urandom};
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic push_rel(logic [31:0] id);
      budget_req_type r;
      r = '{ACT_RELEASE, 8'($urandom), 8'($urandom), 16'($urandom),
            {8'($urandom), 32'($urandom)}, 8'($urandom), id};
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // amount of one class: mostly zero or small, sometimes wide or at max
   function automatic logic [39:0] rand_amt(logic [39:0] maxv, logic [39:0] small_hi);
      int p;
      p = $urandom_range(99);
      if (p < 30) return 40'(0);
      if (p < 80) return 40'($urandom_range(1, 32'(small_hi)));
      if (p < 92) return {8'($urandom), 32'($urandom)} & maxv;
      return maxv;
   endfunction

   function automatic logic [39:0] rand_lim(int style, logic [39:0] maxv, logic [39:0] small_hi);
      case (style)
         0: return maxv;
         1: return {8'($urandom), 32'($urandom)} & maxv;
         2: return 40'($urandom_range(0, 32'(small_hi) * 8));
         default: return 40'(0);
      endcase
   endfunction

   initial begin
      logic [63:0] lo;
      int          acq_pct, style;
      for (int k = 0; k < 5; k++) begin
         lim[k] = 0;
         used[k] = 0;
      end
      peak_bytes = 0;
      issued_id = 0;
      reject_cnt = 0;
      held_cnt = 0;
      for (int i = 0; i < Depth; i++) slot_held[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero limits refuse everything, empty and unknown ids
      set_limits(0, 0, 0, 0, 0);
      push_acq(0, 0, 0, 0, 0);
      push_acq(1, 0, 0, 0, 0);
      push_acq(0, 0, 0, 0, 1);
      push_acq(0, 0, 0, 40'd1, 0);
      push_rel(0);
      push_rel(32'hFFFF_FFFF);

      // directed: widest limits, largest requests, release and reuse
      set_limits(8'hFF, 8'hFF, 16'hFFFF, BytesMax, 8'hFF);
      push_acq(8'hFF, 8'hFF, 16'hFFFF, BytesMax, 8'hFF);
      push_acq(0, 1, 0, 0, 0);
      push_acq(0, 0, 1, 0, 0);
      push_acq(0, 0, 0, 1, 0);
      push_acq(0, 0, 0, 0, 1);
      push_acq(1, 0, 0, 0, 0);
      push_rel(1);
      push_rel(1);
      push_acq(1, 2, 3, 40'd4, 5);
      push_acq(0, 0, 0, BytesMax, 0);
      push_rel(2);
      push_rel(3);
      push_acq(0, 0, 16'h8000, 40'h80_0000_0000, 0);

      // directed: lower limits below what is held
      set_limits(8'hFF, 8'hFF, 16'hFFFF, 40'd100, 8'hFF);
      push_acq(1, 0, 0, 0, 0);
      push_acq(0, 0, 0, 40'd1, 0);
      push_rel(4);
      push_rel(issued_id[31:0] + 1);

      // random phases; one leans on acquires to fill the table
      for (int ph = 0; ph < 9; ph++) begin
         style = (ph == 2) ? 0 : $urandom_range(0, 3);
         if (ph == 8) style = 2;
         set_limits(rand_lim(style, 8'hFF, 8), rand_lim(style, 8'hFF, 8),
                    rand_lim(style, 16'hFFFF, 30), rand_lim(style, BytesMax, 4096),
                    rand_lim(style, 8'hFF, 8));
         acq_pct = (ph == 2) ? 92 : 55;
         for (int n = 0; n < 200; n++) begin
            while (pending_reqs.size() >= 3) @(posedge clock);
            if ($urandom_range(99) < acq_pct) begin
               push_acq(8'(rand_amt(8'hFF, 3)), 8'(rand_amt(8'hFF, 3)),
                        16'(rand_amt(16'hFFFF, 10)), rand_amt(BytesMax, 1024),
                        8'(rand_amt(8'hFF, 3)));
            end else begin
               case ($urandom_range(9))
                  0: push_rel(0);
                  1: push_rel($urandom);
                  default: begin
                     lo = (issued_id > 70) ? issued_id - 70 : 1;
                     push_rel($urandom_range(32'(lo), 32'(issued_id) + 2));
                  end
               endcase
            end
         end
      end

      drain();
      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         err_cnt++;
      end
      $display("covered %0d admissions, %0d saturations, %0d table-full refusals,",
               admits, sats, fulls);
      $display("and %0d releases over several limit settings", frees);
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/mcab_pkg.sv
rtl/core/mcab_front.sv
rtl/core/mcab_back.sv
rtl/core/multi_class_admission_budget.sv
verif/tb_multi_class_admission_budget.sv
